/* sv/ctd_pkg.sv */
package ctd_pkg;

  localparam int CAL_SAMPLES_DEFAULT = 16;
  localparam int FRAC_BITS_DEFAULT   = 8;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [15:0] TOUCH_MARGIN_RESET    = 16'd100;
  localparam logic [15:0] ON_THRESHOLD_RESET    = 16'd200;
  localparam logic [3:0]  RELEASE_HOLDOFF_RESET = 4'd5;
  localparam logic [7:0]  BRIGHT_STEP_RESET     = 8'd5;
  localparam logic [7:0]  BRIGHT_MAX_RESET      = 8'd255;

  localparam logic        LED_RESET     = 1'b1;
  localparam logic [3:0]  HOLDOFF_RESET = 4'd5;

  typedef enum logic [2:0] {
    REG_TOUCH_MARGIN    = 3'd0,
    REG_ON_THRESHOLD    = 3'd1,
    REG_RELEASE_HOLDOFF = 3'd2,
    REG_BRIGHT_STEP     = 3'd3,
    REG_BRIGHT_MAX      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] touch_margin;
    logic [15:0] on_threshold;
    logic [3:0]  release_holdoff;
    logic [7:0]  bright_step;
    logic [7:0]  bright_max;
  } cfg_t;

endpackage

/* sv/ctd_regs.sv */
module ctd_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ctd_pkg::ADDR_W-1:0] paddr,
  input  logic [ctd_pkg::DATA_W-1:0] pwdata,
  output logic [ctd_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output ctd_pkg::cfg_t              cfg
);

  logic                 wr_en;
  ctd_pkg::reg_idx_t    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  // word address; byte offset bits are ignored
  assign idx    = ctd_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.touch_margin    <= ctd_pkg::TOUCH_MARGIN_RESET;
      cfg.on_threshold    <= ctd_pkg::ON_THRESHOLD_RESET;
      cfg.release_holdoff <= ctd_pkg::RELEASE_HOLDOFF_RESET;
      cfg.bright_step     <= ctd_pkg::BRIGHT_STEP_RESET;
      cfg.bright_max      <= ctd_pkg::BRIGHT_MAX_RESET;
    end else if (wr_en) begin
      unique case (idx)
        ctd_pkg::REG_TOUCH_MARGIN:    cfg.touch_margin    <= pwdata[15:0];
        ctd_pkg::REG_ON_THRESHOLD:    cfg.on_threshold    <= pwdata[15:0];
        ctd_pkg::REG_RELEASE_HOLDOFF: cfg.release_holdoff <= pwdata[3:0];
        ctd_pkg::REG_BRIGHT_STEP:     cfg.bright_step     <= pwdata[7:0];
        ctd_pkg::REG_BRIGHT_MAX:      cfg.bright_max      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ctd_pkg::REG_TOUCH_MARGIN:    prdata = {16'd0, cfg.touch_margin};
      ctd_pkg::REG_ON_THRESHOLD:    prdata = {16'd0, cfg.on_threshold};
      ctd_pkg::REG_RELEASE_HOLDOFF: prdata = {28'd0, cfg.release_holdoff};
      ctd_pkg::REG_BRIGHT_STEP:     prdata = {24'd0, cfg.bright_step};
      ctd_pkg::REG_BRIGHT_MAX:      prdata = {24'd0, cfg.bright_max};
      default:                      prdata = '0;
    endcase
  end

endmodule

/* sv/capacitive_touch_toggle_dimmer_unit.sv */
// Capacitive touch toggle dimmer. Takes one oscillator count per transaction and
// returns one result per count, in order. One count is accepted every clock while
// the output is not stalled; the count lands in the input register at the accepting
// edge and its result is then registered in the result register, raising out_valid;
// a stalled output holds the count in the input register. The rate is set by the
// per-sample state update loop (running average, baseline tracking, touch decision,
// LED toggle and brightness ramp), which is combinational. The first CAL_SAMPLES
// counts calibrate the average and baseline and report calibrating with no touch. Average
// and baseline are unsigned fixed point with FRAC_BITS fraction bits; average_level is the
// integer part. Registers sit on the APB port at byte address 4*index and should
// be written only while no transaction is in flight.
module capacitive_touch_toggle_dimmer_unit #(
  parameter int CAL_SAMPLES = ctd_pkg::CAL_SAMPLES_DEFAULT,
  parameter int FRAC_BITS   = ctd_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [15:0]                cap_count,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       calibrating,
  output logic                       touched,
  output logic                       led_on,
  output logic [7:0]                 brightness,
  output logic [15:0]                average_level,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ctd_pkg::ADDR_W-1:0] paddr,
  input  logic [ctd_pkg::DATA_W-1:0] pwdata,
  output logic [ctd_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int QW    = 16 + FRAC_BITS;
  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
  localparam int PW    = 2 * QW + 1;
  localparam int SH    = QW + 4;
  // reciprocal constants, exact floor division for any QW-bit dividend
  localparam logic [QW:0] DIV15_M = (QW+1)'(((64'd1 << SH) / 64'd15) + 64'd1);
  localparam logic [QW:0] DIV10_M = (QW+1)'(((64'd1 << SH) / 64'd10) + 64'd1);

  ctd_pkg::cfg_t cfg;

  ctd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  logic        in_reg_valid;
  logic [15:0] cap_reg;
  logic        advance;
  logic        in_accept;

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = in_reg_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  // state
  logic [QW-1:0]    average_q;
  logic [QW-1:0]    baseline_q;
  logic [CNT_W-1:0] sample_counter;
  logic             switch_latched;
  logic             led_state;
  logic [3:0]       holdoff_counter;
  logic [7:0]       duty_level;

  logic [QW-1:0]    average_q_next;
  logic [QW-1:0]    baseline_q_next;
  logic             switch_latched_next;
  logic             led_state_next;
  logic [3:0]       holdoff_counter_next;
  logic [7:0]       duty_level_next;

  logic             cal;
  logic             touch;
  logic [QW-1:0]    cap_q;
  logic [QW-1:0]    margin_q;
  logic [QW-1:0]    thr_q;
  logic [QW+3:0]    sum_cal;
  logic [QW+1:0]    sum_run;
  logic [PW-1:0]    prod15;
  logic [PW-1:0]    prod10;
  logic [QW-4:0]    quot10;
  logic [QW-1:0]    quot10_x10;
  logic [QW-1:0]    ceil10;
  logic [QW-1:0]    gain;
  logic             dip;
  logic [QW:0]      base_add;
  logic [8:0]       duty_add;

  assign cal      = sample_counter < CNT_W'(CAL_SAMPLES);
  assign cap_q    = {cap_reg, {FRAC_BITS{1'b0}}};
  assign margin_q = {cfg.touch_margin, {FRAC_BITS{1'b0}}};
  assign thr_q    = {cfg.on_threshold, {FRAC_BITS{1'b0}}};

  assign sum_cal = ({4'd0, average_q} << 4) - {4'd0, average_q} + {4'd0, cap_q};
  assign sum_run = ({2'd0, average_q} << 1) + {2'd0, average_q} + {2'd0, cap_q};

  always_comb begin
    if (cal) begin
      average_q_next = sum_cal[QW+3:4];
    end else begin
      average_q_next = sum_run[QW+1:2];
    end
  end

  assign prod15 = PW'(average_q_next) * PW'(DIV15_M);

  // baseline * 9 / 10, floored, as baseline - ceil(baseline / 10)
  assign prod10     = PW'(baseline_q) * PW'(DIV10_M);
  assign quot10     = prod10[PW-1:SH];
  assign quot10_x10 = (QW'(quot10) << 3) + (QW'(quot10) << 1);
  assign ceil10     = QW'(quot10) + QW'(quot10_x10 != baseline_q);

  assign gain = cal ? QW'(prod15[PW-1:SH]) : (average_q_next >> 2);
  assign dip  = ({1'b0, cap_q} + {1'b0, margin_q}) <= {1'b0, average_q_next};
  assign base_add = {1'b0, baseline_q} + {1'b0, gain};

  always_comb begin
    priority if (dip) begin
      baseline_q_next = (base_add > {1'b0, average_q_next}) ? average_q_next
                                                            : base_add[QW-1:0];
    end else if (cal) begin
      baseline_q_next = baseline_q - ceil10;
    end else begin
      baseline_q_next = '0;
    end
  end

  assign touch = !cal && (cap_reg != 16'd0) &&
                 ({1'b0, average_q_next} >= ({1'b0, baseline_q_next} + {1'b0, thr_q}));

  assign duty_add = {1'b0, duty_level} + {1'b0, cfg.bright_step};

  always_comb begin
    switch_latched_next  = switch_latched;
    led_state_next       = led_state;
    holdoff_counter_next = holdoff_counter;
    duty_level_next      = duty_level;
    if (!cal) begin
      priority if (touch) begin
        if (!switch_latched) begin
          switch_latched_next  = 1'b1;
          led_state_next       = !led_state;
          holdoff_counter_next = cfg.release_holdoff;
        end
      end else if (holdoff_counter != 4'd0) begin
        holdoff_counter_next = holdoff_counter - 4'd1;
      end else begin
        switch_latched_next = 1'b0;
      end
      if (led_state_next) begin
        duty_level_next = (duty_add > {1'b0, cfg.bright_max}) ? cfg.bright_max
                                                              : duty_add[7:0];
      end else begin
        duty_level_next = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid    <= 1'b0;
      out_valid       <= 1'b0;
      average_q       <= '0;
      baseline_q      <= '0;
      sample_counter  <= '0;
      switch_latched  <= 1'b0;
      led_state       <= ctd_pkg::LED_RESET;
      holdoff_counter <= ctd_pkg::HOLDOFF_RESET;
      duty_level      <= 8'd0;
    end else begin
      if (in_accept) begin
        in_reg_valid <= 1'b1;
        cap_reg      <= cap_count;
      end else if (advance) begin
        in_reg_valid <= 1'b0;
      end

      if (in_reg_valid && advance) begin
        average_q       <= average_q_next;
        baseline_q      <= baseline_q_next;
        switch_latched  <= switch_latched_next;
        led_state       <= led_state_next;
        holdoff_counter <= holdoff_counter_next;
        duty_level      <= duty_level_next;
        if (cal) begin
          sample_counter <= sample_counter + CNT_W'(1);
        end
        out_valid     <= 1'b1;
        calibrating   <= cal;
        touched       <= touch;
        led_on        <= led_state_next;
        brightness    <= duty_level_next;
        average_level <= average_q_next[QW-1:FRAC_BITS];
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
